FILE: rtl/core/ajbc_pkg.sv
// Shared types, constants and profile functions of the adaptive jitter buffer controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ajbc_pkg;

   localparam int unsigned PENDING_DEPTH_DEFAULT = 16;
   localparam int unsigned MAX_IN_FLIGHT_DEFAULT = 10;

   localparam int unsigned OP_W       = 3;
   localparam int unsigned BYTES_W    = 16;
   localparam int unsigned NOW_W      = 48;
   localparam int unsigned DUR_W      = 8;
   localparam int unsigned DROPS_W    = 5;
   localparam int unsigned SUM_OUT_W  = 12;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned RS_TOTAL_W = 16;
   localparam int unsigned PLAYED_W   = 16;
   localparam int unsigned OVL_W      = 4;
   localparam int unsigned PROF_W     = 2;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned RATE_W      = 18;
   localparam int unsigned CHAN_W      = 4;
   localparam int unsigned LIMIT_W     = 10;
   localparam int unsigned HOLD_W      = 24;

   localparam int unsigned BPS_W    = RATE_W + CHAN_W + 1;
   localparam int unsigned NUM_W    = 27;
   localparam int unsigned DIV_STEPS = DUR_W;
   localparam int unsigned DIV_W    = BPS_W + DIV_STEPS - 1;
   localparam int unsigned DCNT_W   = $clog2(DIV_STEPS);

   localparam logic [RATE_W-1:0]  RESET_SAMPLE_RATE   = 18'd48000;
   localparam logic [CHAN_W-1:0]  RESET_CHANNELS      = 4'd2;
   localparam logic [LIMIT_W-1:0] RESET_MAX_PENDING   = 10'd120;
   localparam logic [LIMIT_W-1:0] RESET_HARD_TOTAL    = 10'd130;
   localparam logic [LIMIT_W-1:0] RESET_STEADY_TARGET = 10'd50;
   localparam logic [LIMIT_W-1:0] RESET_STEADY_SOFT   = 10'd70;
   localparam logic [LIMIT_W-1:0] RESET_STEADY_CAP    = 10'd40;
   localparam logic [HOLD_W-1:0]  RESET_RECOVERY_HOLD = 24'd1500000;

   localparam logic [LIMIT_W-1:0] STARTUP_CAP_MS     = 10'd50;
   localparam logic [LIMIT_W-1:0] STARTUP_TARGET_MS  = 10'd60;
   localparam logic [LIMIT_W-1:0] STARTUP_SOFT_MS    = 10'd80;
   localparam logic [LIMIT_W-1:0] RECOVERY_CAP_MS    = 10'd60;
   localparam logic [LIMIT_W-1:0] RECOVERY_TARGET_MS = 10'd70;
   localparam logic [LIMIT_W-1:0] RECOVERY_SOFT_MS   = 10'd90;

   localparam logic [PLAYED_W-1:0] WARMUP_FRAMES    = 16'd14;
   localparam logic [NOW_W-1:0]    WARMUP_US        = 48'd200000;
   localparam logic [NOW_W-1:0]    WINDOW_US        = 48'd800000;
   localparam logic [NOW_W-1:0]    COOLDOWN_US      = 48'd1500000;
   localparam logic [OVL_W-1:0]    EVENTS_TO_RECOVER = 4'd2;
   localparam logic [OVL_W-1:0]    EVENTS_TO_RESYNC  = 4'd5;
   localparam logic [BYTES_W-1:0]  MS_PER_S          = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_RATE   = 3'd0,
      CSR_CHANNEL_COUNT = 3'd1,
      CSR_MAX_PENDING   = 3'd2,
      CSR_HARD_TOTAL    = 3'd3,
      CSR_STEADY_TARGET = 3'd4,
      CSR_STEADY_SOFT   = 3'd5,
      CSR_STEADY_CAP    = 3'd6,
      CSR_RECOVERY_HOLD = 3'd7
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_FRAME   = 3'd0,
      OP_SERVICE = 3'd1,
      OP_DONE    = 3'd2,
      OP_OPEN    = 3'd3,
      OP_STOP    = 3'd4
   } op_type;

   typedef enum logic [PROF_W-1:0] {
      PROF_STARTUP  = 2'd0,
      PROF_STEADY   = 2'd1,
      PROF_RECOVERY = 2'd2
   } profile_type;

   typedef enum logic [1:0] {
      TRIM_PENDING  = 2'd0,
      TRIM_HARD     = 2'd1,
      TRIM_RECOVERY = 2'd2,
      TRIM_TARGET   = 2'd3
   } trim_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_DUR_MUL, ST_DUR_NUM, ST_DUR_INIT, ST_DUR_DIV,
      ST_FULL_DROP, ST_ENQ, ST_TRIM_CHK, ST_TRIM_DROP, ST_SVC_PROF, ST_SVC_SOFT,
      ST_OVL_COUNT, ST_OVL_HOLD, ST_OVL_DECIDE, ST_RESYNC, ST_SUB_PROF, ST_SUBMIT,
      ST_RETIRE, ST_OPEN, ST_STOP, ST_FINISH, ST_OUT
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     bps_calc;
      logic     num_calc;
      logic     div_init;
      logic     div_step;
      logic     drop;
      logic     enqueue;
      trim_type trim;
      logic     prof_load;
      logic     ovl_count;
      logic     ovl_hold;
      logic     ovl_decide;
      logic     resync;
      logic     submit;
      logic     retire;
      logic     open_session;
      logic     stop;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            running;
      logic            bytes_nz;
      logic            pend_full;
      logic            trim_need;
      logic            soft_over;
      logic            resync_ok;
      logic            submit_ok;
      logic            inflight_nz;
   } sts_type;

   function automatic logic [LIMIT_W-1:0] prof_cap(input profile_type p,
                                                   input logic [LIMIT_W-1:0] steady);
      logic [LIMIT_W-1:0] v;
      unique case (p)
         PROF_RECOVERY: v = RECOVERY_CAP_MS;
         PROF_STEADY:   v = steady;
         default:       v = STARTUP_CAP_MS;
      endcase
      return v;
   endfunction

   function automatic logic [LIMIT_W-1:0] prof_target(input profile_type p,
                                                      input logic [LIMIT_W-1:0] steady);
      logic [LIMIT_W-1:0] v;
      unique case (p)
         PROF_RECOVERY: v = RECOVERY_TARGET_MS;
         PROF_STEADY:   v = steady;
         default:       v = STARTUP_TARGET_MS;
      endcase
      return v;
   endfunction

   function automatic logic [LIMIT_W-1:0] prof_soft(input profile_type p,
                                                    input logic [LIMIT_W-1:0] steady);
      logic [LIMIT_W-1:0] v;
      unique case (p)
         PROF_RECOVERY: v = RECOVERY_SOFT_MS;
         PROF_STEADY:   v = steady;
         default:       v = STARTUP_SOFT_MS;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ajbc_datapath.sv
// Datapath of the jitter buffer controller: queues, sums, timers, divider and result register.
// Depends on ajbc_pkg; driven by ajbc_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none
module ajbc_datapath #(
   parameter int unsigned PENDING_DEPTH = ajbc_pkg::PENDING_DEPTH_DEFAULT,
   parameter int unsigned MAX_IN_FLIGHT = ajbc_pkg::MAX_IN_FLIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [ajbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ajbc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [ajbc_pkg::OP_W-1:0]          req_op,
   input  wire logic [ajbc_pkg::BYTES_W-1:0]       req_frame_bytes,
   input  wire logic [ajbc_pkg::NOW_W-1:0]         req_now_us,
   input  wire ajbc_pkg::cmd_type                  cmd,
   output ajbc_pkg::sts_type                       sts,
   output logic                                    rsp_accepted,
   output logic                                    rsp_submit_valid,
   output logic [ajbc_pkg::DUR_W-1:0]              rsp_submit_ms,
   output logic [ajbc_pkg::DROPS_W-1:0]            rsp_dropped_now,
   output logic                                    rsp_resync,
   output logic [ajbc_pkg::PROF_W-1:0]             rsp_profile,
   output logic [ajbc_pkg::SUM_OUT_W-1:0]          rsp_pending_ms,
   output logic [ajbc_pkg::SUM_OUT_W-1:0]          rsp_submitted_ms,
   output logic [ajbc_pkg::TOTAL_W-1:0]            rsp_dropped_total,
   output logic [ajbc_pkg::TOTAL_W-1:0]            rsp_played_total,
   output logic [ajbc_pkg::RS_TOTAL_W-1:0]         rsp_resync_total
);
   import ajbc_pkg::*;

   localparam int unsigned PIDX_W = $clog2(PENDING_DEPTH);
   localparam int unsigned PCNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int unsigned PSUM_W = DUR_W + PCNT_W;
   localparam int unsigned IIDX_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1;
   localparam int unsigned ICNT_W = $clog2(MAX_IN_FLIGHT + 1);
   localparam int unsigned ISUM_W = DUR_W + ICNT_W;
   localparam int unsigned TOT_W  = ((PSUM_W > ISUM_W) ? PSUM_W : ISUM_W) + 1;
   localparam int unsigned SAT_W  = (TOT_W > SUM_OUT_W) ? TOT_W : SUM_OUT_W;
   localparam logic [PIDX_W:0] PDEPTH_X = (PIDX_W + 1)'(PENDING_DEPTH);
   localparam logic [IIDX_W:0] IDEPTH_X = (IIDX_W + 1)'(MAX_IN_FLIGHT);

   logic [RATE_W-1:0]  rate_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [LIMIT_W-1:0] max_pend_ff, hard_ff, s_target_ff, s_soft_ff, s_cap_ff;
   logic [HOLD_W-1:0]  hold_ff;

   logic [OP_W-1:0]    op_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [NOW_W-1:0]   now_ff;

   logic [BPS_W-1:0]          bps_ff;
   logic [NUM_W-1:0]          bk_ff, num_ff, rem_ff;
   logic [DIV_W-1:0]          div_ff;
   logic [DUR_W-1:0]          q_ff;
   logic                      sat_ff;
   logic [RATE_W+CHAN_W-1:0]  rc_prod;
   logic                      div_ge;
   logic [DUR_W-1:0]          dur;

   logic [DUR_W-1:0]  pend_mem [PENDING_DEPTH];
   logic [DUR_W-1:0]  pend_rd_ff;
   logic [PIDX_W-1:0] pend_head_ff, pend_head_nx, pend_tail;
   logic [PIDX_W:0]   pend_tail_sum;
   logic [PCNT_W-1:0] pend_count_ff;
   logic [PSUM_W-1:0] pend_sum_ff;

   logic [DUR_W-1:0]  inf_mem [MAX_IN_FLIGHT];
   logic [DUR_W-1:0]  inf_rd_ff;
   logic [IIDX_W-1:0] inf_head_ff, inf_head_nx, inf_tail;
   logic [IIDX_W:0]   inf_tail_sum;
   logic [ICNT_W-1:0] inf_count_ff;
   logic [ISUM_W-1:0] inf_sum_ff;

   logic                  running_ff;
   logic [NOW_W-1:0]      started_ff, rec_until_ff, last_ovl_ff, last_rs_ff, hold_sum_ff;
   logic [PLAYED_W-1:0]   played_ff;
   logic [OVL_W-1:0]      ovl_cnt_ff;
   logic [TOTAL_W-1:0]    drop_total_ff, play_total_ff;
   logic [RS_TOTAL_W-1:0] rs_total_ff;
   profile_type           prof_ff, prof_now;

   logic                  res_acc_ff, res_sub_ff, res_rs_ff;
   logic [DUR_W-1:0]      res_ms_ff;
   logic [DROPS_W-1:0]    drops_ff;

   logic [NOW_W-1:0]   elapsed, ovl_gap, rs_gap;
   logic [NOW_W:0]     hold_sum;
   logic               warm, restart, cool_ok;
   logic [TOT_W-1:0]   total, trim_val;
   logic [LIMIT_W-1:0] trim_limit;
   logic [SAT_W-1:0]   pend_x, inf_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= RESET_SAMPLE_RATE;
         chan_ff     <= RESET_CHANNELS;
         max_pend_ff <= RESET_MAX_PENDING;
         hard_ff     <= RESET_HARD_TOTAL;
         s_target_ff <= RESET_STEADY_TARGET;
         s_soft_ff   <= RESET_STEADY_SOFT;
         s_cap_ff    <= RESET_STEADY_CAP;
         hold_ff     <= RESET_RECOVERY_HOLD;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_RATE:   rate_ff     <= csr_wdata[RATE_W-1:0];
            CSR_CHANNEL_COUNT: chan_ff     <= csr_wdata[CHAN_W-1:0];
            CSR_MAX_PENDING:   max_pend_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_HARD_TOTAL:    hard_ff     <= csr_wdata[LIMIT_W-1:0];
            CSR_STEADY_TARGET: s_target_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_STEADY_SOFT:   s_soft_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_STEADY_CAP:    s_cap_ff    <= csr_wdata[LIMIT_W-1:0];
            CSR_RECOVERY_HOLD: hold_ff     <= csr_wdata[HOLD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         bytes_ff <= req_frame_bytes;
         now_ff   <= req_now_us;
      end
   end

   // Duration: the saturation test comes first, so the quotient needs only eight steps.
   assign rc_prod = (RATE_W + CHAN_W)'(rate_ff) * (RATE_W + CHAN_W)'(chan_ff);
   assign div_ge  = DIV_W'(rem_ff) >= div_ff;

   always_ff @(posedge clock) begin
      if (cmd.bps_calc) begin
         bps_ff <= {rc_prod, 1'b0};
         bk_ff  <= NUM_W'(bytes_ff) * NUM_W'(MS_PER_S);
      end
      if (cmd.num_calc) begin
         num_ff <= bk_ff + NUM_W'(bps_ff) - NUM_W'(1);
      end
      if (cmd.div_init) begin
         rem_ff <= num_ff;
         div_ff <= DIV_W'(bps_ff) << (DIV_STEPS - 1);
         q_ff   <= '0;
         sat_ff <= (BPS_W + DUR_W)'(num_ff) >= {bps_ff, DUR_W'(0)};
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? NUM_W'(DIV_W'(rem_ff) - div_ff) : rem_ff;
         div_ff <= div_ff >> 1;
         q_ff   <= {q_ff[DUR_W-2:0], div_ge};
      end
   end

   always_comb begin
      priority if (bps_ff == '0) dur = '0;
      else if (sat_ff)           dur = '1;
      else if (q_ff == '0)       dur = DUR_W'(1);
      else                       dur = q_ff;
   end

   assign pend_head_nx  = (pend_head_ff == PIDX_W'(PENDING_DEPTH - 1)) ? '0 : pend_head_ff + 1'b1;
   assign pend_tail_sum = {1'b0, pend_head_ff} + (PIDX_W + 1)'(pend_count_ff);
   assign pend_tail     = (pend_tail_sum >= PDEPTH_X) ? PIDX_W'(pend_tail_sum - PDEPTH_X)
                                                      : PIDX_W'(pend_tail_sum);
   assign inf_head_nx   = (inf_head_ff == IIDX_W'(MAX_IN_FLIGHT - 1)) ? '0 : inf_head_ff + 1'b1;
   assign inf_tail_sum  = {1'b0, inf_head_ff} + (IIDX_W + 1)'(inf_count_ff);
   assign inf_tail      = (inf_tail_sum >= IDEPTH_X) ? IIDX_W'(inf_tail_sum - IDEPTH_X)
                                                     : IIDX_W'(inf_tail_sum);

   always_ff @(posedge clock) begin
      if (cmd.enqueue) pend_mem[pend_tail] <= dur;
      pend_rd_ff <= pend_mem[pend_head_ff];
      if (cmd.submit) inf_mem[inf_tail] <= pend_rd_ff;
      inf_rd_ff <= inf_mem[inf_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_head_ff  <= '0;
         pend_count_ff <= '0;
         pend_sum_ff   <= '0;
      end else begin
         priority if (cmd.open_session || cmd.stop) begin
            pend_head_ff  <= '0;
            pend_count_ff <= '0;
            pend_sum_ff   <= '0;
         end else if (cmd.drop || cmd.submit) begin
            pend_head_ff  <= pend_head_nx;
            pend_count_ff <= pend_count_ff - 1'b1;
            pend_sum_ff   <= pend_sum_ff - PSUM_W'(pend_rd_ff);
         end else if (cmd.enqueue) begin
            pend_count_ff <= pend_count_ff + 1'b1;
            pend_sum_ff   <= pend_sum_ff + PSUM_W'(dur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inf_head_ff  <= '0;
         inf_count_ff <= '0;
         inf_sum_ff   <= '0;
      end else begin
         priority if (cmd.open_session || cmd.stop || cmd.resync) begin
            inf_head_ff  <= '0;
            inf_count_ff <= '0;
            inf_sum_ff   <= '0;
         end else if (cmd.submit) begin
            inf_count_ff <= inf_count_ff + 1'b1;
            inf_sum_ff   <= inf_sum_ff + ISUM_W'(pend_rd_ff);
         end else if (cmd.retire) begin
            inf_head_ff  <= inf_head_nx;
            inf_count_ff <= inf_count_ff - 1'b1;
            inf_sum_ff   <= inf_sum_ff - ISUM_W'(inf_rd_ff);
         end
      end
   end

   assign elapsed  = now_ff - started_ff;
   assign ovl_gap  = now_ff - last_ovl_ff;
   assign rs_gap   = now_ff - last_rs_ff;
   assign hold_sum = {1'b0, now_ff} + (NOW_W + 1)'(hold_ff);
   assign warm     = (started_ff != '0) && (now_ff > started_ff) && (elapsed >= WARMUP_US)
                     && (played_ff >= WARMUP_FRAMES);
   assign restart  = (last_ovl_ff == '0) || ((now_ff >= last_ovl_ff) && (ovl_gap > WINDOW_US));
   assign cool_ok  = (last_rs_ff == '0) || ((now_ff >= last_rs_ff) && (rs_gap >= COOLDOWN_US));

   always_comb begin
      priority if (rec_until_ff > now_ff) prof_now = PROF_RECOVERY;
      else if (warm)                      prof_now = PROF_STEADY;
      else                                prof_now = PROF_STARTUP;
   end

   always_ff @(posedge clock) begin
      if (cmd.prof_load) prof_ff <= prof_now;
      if (cmd.ovl_hold)  hold_sum_ff <= hold_sum[NOW_W] ? '1 : hold_sum[NOW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         started_ff    <= '0;
         played_ff     <= '0;
         rec_until_ff  <= '0;
         ovl_cnt_ff    <= '0;
         last_ovl_ff   <= '0;
         last_rs_ff    <= '0;
         drop_total_ff <= '0;
         play_total_ff <= '0;
         rs_total_ff   <= '0;
      end else begin
         priority if (cmd.open_session) begin
            running_ff    <= 1'b1;
            started_ff    <= now_ff;
            played_ff     <= '0;
            rec_until_ff  <= '0;
            ovl_cnt_ff    <= '0;
            last_ovl_ff   <= '0;
            last_rs_ff    <= '0;
            drop_total_ff <= '0;
            play_total_ff <= '0;
            rs_total_ff   <= '0;
         end else if (cmd.stop) begin
            running_ff <= 1'b0;
         end else if (cmd.drop) begin
            if (drop_total_ff != '1) drop_total_ff <= drop_total_ff + 1'b1;
         end else if (cmd.retire) begin
            if (play_total_ff != '1) play_total_ff <= play_total_ff + 1'b1;
            if (played_ff != '1)     played_ff     <= played_ff + 1'b1;
         end else if (cmd.ovl_count) begin
            last_ovl_ff <= now_ff;
            priority if (restart)      ovl_cnt_ff <= OVL_W'(1);
            else if (ovl_cnt_ff != '1) ovl_cnt_ff <= ovl_cnt_ff + 1'b1;
         end else if (cmd.ovl_decide) begin
            if (ovl_cnt_ff >= EVENTS_TO_RECOVER && hold_sum_ff > rec_until_ff) begin
               rec_until_ff <= hold_sum_ff;
            end
         end else if (cmd.resync) begin
            last_rs_ff <= now_ff;
            ovl_cnt_ff <= '0;
            started_ff <= now_ff;
            played_ff  <= '0;
            if (rs_total_ff != '1) rs_total_ff <= rs_total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_acc_ff <= 1'b0;
         res_sub_ff <= 1'b0;
         res_rs_ff  <= 1'b0;
         res_ms_ff  <= '0;
         drops_ff   <= '0;
      end else begin
         if (cmd.enqueue) res_acc_ff <= 1'b1;
         if (cmd.resync)  res_rs_ff  <= 1'b1;
         if (cmd.submit) begin
            res_sub_ff <= 1'b1;
            res_ms_ff  <= pend_rd_ff;
         end
         if (cmd.drop && drops_ff != '1) drops_ff <= drops_ff + 1'b1;
      end
   end

   assign total = TOT_W'(pend_sum_ff) + TOT_W'(inf_sum_ff);

   always_comb begin
      unique case (cmd.trim)
         TRIM_PENDING:  trim_limit = max_pend_ff;
         TRIM_HARD:     trim_limit = hard_ff;
         TRIM_RECOVERY: trim_limit = RECOVERY_TARGET_MS;
         default:       trim_limit = prof_target(prof_ff, s_target_ff);
      endcase
   end
   assign trim_val = (cmd.trim == TRIM_PENDING) ? TOT_W'(pend_sum_ff) : total;

   assign sts.op          = op_ff;
   assign sts.running     = running_ff;
   assign sts.bytes_nz    = bytes_ff != '0;
   assign sts.pend_full   = pend_count_ff == PCNT_W'(PENDING_DEPTH);
   assign sts.trim_need   = (pend_count_ff != '0) && (trim_val > TOT_W'(trim_limit));
   assign sts.soft_over   = total > TOT_W'(prof_soft(prof_ff, s_soft_ff));
   assign sts.resync_ok   = (ovl_cnt_ff >= EVENTS_TO_RESYNC) && cool_ok;
   assign sts.submit_ok   = (pend_count_ff != '0) && (inf_count_ff < ICNT_W'(MAX_IN_FLIGHT))
                            && (TOT_W'(inf_sum_ff) < TOT_W'(prof_cap(prof_ff, s_cap_ff)));
   assign sts.inflight_nz = inf_count_ff != '0;

   assign pend_x = SAT_W'(pend_sum_ff);
   assign inf_x  = SAT_W'(inf_sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted      <= res_acc_ff;
         rsp_submit_valid  <= res_sub_ff;
         rsp_submit_ms     <= res_ms_ff;
         rsp_dropped_now   <= drops_ff;
         rsp_resync        <= res_rs_ff;
         rsp_profile       <= prof_ff;
         rsp_pending_ms    <= (pend_x > SAT_W'({SUM_OUT_W{1'b1}})) ? '1 : SUM_OUT_W'(pend_x);
         rsp_submitted_ms  <= (inf_x > SAT_W'({SUM_OUT_W{1'b1}})) ? '1 : SUM_OUT_W'(inf_x);
         rsp_dropped_total <= drop_total_ff;
         rsp_played_total  <= play_total_ff;
         rsp_resync_total  <= rs_total_ff;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/ajbc_ctrl.sv
// Controller of the jitter buffer: sequences each item through the datapath steps.
// Depends on ajbc_pkg; drives ajbc_datapath through the command struct.
`timescale 1ns / 1ps
`default_nettype none
module ajbc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire ajbc_pkg::sts_type  sts,
   output ajbc_pkg::cmd_type       cmd
);
   import ajbc_pkg::*;

   state_type          state_ff, state_in;
   trim_type           trim_ff, trim_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trim_ff      <= TRIM_PENDING;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trim_ff      <= trim_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      trim_in  = trim_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (sts.op)
               OP_FRAME:   state_in = (sts.running && sts.bytes_nz) ? ST_DUR_MUL : ST_FINISH;
               OP_SERVICE: state_in = sts.running ? ST_SVC_PROF : ST_FINISH;
               OP_DONE:    state_in = sts.inflight_nz ? ST_RETIRE : ST_FINISH;
               OP_OPEN:    state_in = ST_OPEN;
               OP_STOP:    state_in = ST_STOP;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_DUR_MUL:  state_in = ST_DUR_NUM;
         ST_DUR_NUM:  state_in = ST_DUR_INIT;
         ST_DUR_INIT: begin
            cnt_in   = DCNT_W'(DIV_STEPS - 1);
            state_in = ST_DUR_DIV;
         end
         ST_DUR_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_FULL_DROP;
         end
         ST_FULL_DROP: state_in = ST_ENQ;
         ST_ENQ: begin
            trim_in  = TRIM_PENDING;
            state_in = ST_TRIM_CHK;
         end
         ST_TRIM_CHK: begin
            if (sts.trim_need) begin
               state_in = ST_TRIM_DROP;
            end else begin
               unique case (trim_ff)
                  TRIM_PENDING:  trim_in  = TRIM_HARD;
                  TRIM_HARD:     state_in = ST_FINISH;
                  TRIM_RECOVERY: state_in = ST_RESYNC;
                  TRIM_TARGET:   state_in = ST_SUB_PROF;
               endcase
            end
         end
         ST_TRIM_DROP:  state_in = ST_TRIM_CHK;
         ST_SVC_PROF:   state_in = ST_SVC_SOFT;
         ST_SVC_SOFT:   state_in = sts.soft_over ? ST_OVL_COUNT : ST_SUB_PROF;
         ST_OVL_COUNT:  state_in = ST_OVL_HOLD;
         ST_OVL_HOLD:   state_in = ST_OVL_DECIDE;
         ST_OVL_DECIDE: begin
            trim_in  = sts.resync_ok ? TRIM_RECOVERY : TRIM_TARGET;
            state_in = ST_TRIM_CHK;
         end
         ST_RESYNC:   state_in = ST_FINISH;
         ST_SUB_PROF: state_in = ST_SUBMIT;
         ST_SUBMIT:   state_in = ST_FINISH;
         ST_RETIRE:   state_in = ST_FINISH;
         ST_OPEN:     state_in = ST_FINISH;
         ST_STOP:     state_in = ST_FINISH;
         ST_FINISH:   state_in = ST_OUT;
         ST_OUT:      if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.trim = trim_ff;
      unique case (state_ff)
         ST_IDLE:       cmd.accept       = req_valid;
         ST_DUR_MUL:    cmd.bps_calc     = 1'b1;
         ST_DUR_NUM:    cmd.num_calc     = 1'b1;
         ST_DUR_INIT:   cmd.div_init     = 1'b1;
         ST_DUR_DIV:    cmd.div_step     = 1'b1;
         ST_FULL_DROP:  cmd.drop         = sts.pend_full;
         ST_ENQ:        cmd.enqueue      = 1'b1;
         ST_TRIM_DROP:  cmd.drop         = 1'b1;
         ST_SVC_PROF:   cmd.prof_load    = 1'b1;
         ST_OVL_COUNT:  cmd.ovl_count    = 1'b1;
         ST_OVL_HOLD:   cmd.ovl_hold     = 1'b1;
         ST_OVL_DECIDE: cmd.ovl_decide   = 1'b1;
         ST_RESYNC:     cmd.resync       = 1'b1;
         ST_SUB_PROF:   cmd.prof_load    = 1'b1;
         ST_SUBMIT:     cmd.submit       = sts.submit_ok;
         ST_RETIRE:     cmd.retire       = 1'b1;
         ST_OPEN:       cmd.open_session = 1'b1;
         ST_STOP:       cmd.stop         = 1'b1;
         ST_FINISH:     cmd.prof_load    = 1'b1;
         ST_OUT:        cmd.load_rsp     = slot_free;
         default:       cmd.accept       = 1'b0;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign req_ready    = state_ff == ST_IDLE;

endmodule
`default_nettype wire

FILE: rtl/core/adaptive_jitter_buffer_controller.sv
// Top level of the adaptive jitter buffer controller: controller, datapath and checks.
// Depends on ajbc_pkg, ajbc_ctrl and ajbc_datapath.
//
//   Channel  Ports   Handshake        Carries
//   request  req_*   valid / ready    op, frame length in bytes, time in microseconds
//   response rsp_*   valid / ready    one result item per request item
//   config   csr_*   write enable     register index and write data, no read-back
//
// One item is in work at a time; the next is taken in the cycle after its result is registered.
// A frame item runs the eight-step duration divider; each trimmed frame adds a drop and a check.
// A soft overload lengthens a service item, as does each frame that it drops.
// Open, stop and retiring done items run their own action state; an ignored item goes to finish.
// Reset is synchronous and leaves both queues empty.
// A stalled response holds in its register; one finished item may wait behind it.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_jitter_buffer_controller #(
   parameter int unsigned PENDING_DEPTH = ajbc_pkg::PENDING_DEPTH_DEFAULT,
   parameter int unsigned MAX_IN_FLIGHT = ajbc_pkg::MAX_IN_FLIGHT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [ajbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ajbc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ajbc_pkg::OP_W-1:0]         req_op,
   input  wire logic [ajbc_pkg::BYTES_W-1:0]      req_frame_bytes,
   input  wire logic [ajbc_pkg::NOW_W-1:0]        req_now_us,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_accepted,
   output logic                                   rsp_submit_valid,
   output logic [ajbc_pkg::DUR_W-1:0]             rsp_submit_ms,
   output logic [ajbc_pkg::DROPS_W-1:0]           rsp_dropped_now,
   output logic                                   rsp_resync,
   output logic [ajbc_pkg::PROF_W-1:0]            rsp_profile,
   output logic [ajbc_pkg::SUM_OUT_W-1:0]         rsp_pending_ms,
   output logic [ajbc_pkg::SUM_OUT_W-1:0]         rsp_submitted_ms,
   output logic [ajbc_pkg::TOTAL_W-1:0]           rsp_dropped_total,
   output logic [ajbc_pkg::TOTAL_W-1:0]           rsp_played_total,
   output logic [ajbc_pkg::RS_TOTAL_W-1:0]        rsp_resync_total
);
   import ajbc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ajbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ajbc_datapath #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .MAX_IN_FLIGHT (MAX_IN_FLIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_op            (req_op),
      .req_frame_bytes   (req_frame_bytes),
      .req_now_us        (req_now_us),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_accepted      (rsp_accepted),
      .rsp_submit_valid  (rsp_submit_valid),
      .rsp_submit_ms     (rsp_submit_ms),
      .rsp_dropped_now   (rsp_dropped_now),
      .rsp_resync        (rsp_resync),
      .rsp_profile       (rsp_profile),
      .rsp_pending_ms    (rsp_pending_ms),
      .rsp_submitted_ms  (rsp_submitted_ms),
      .rsp_dropped_total (rsp_dropped_total),
      .rsp_played_total  (rsp_played_total),
      .rsp_resync_total  (rsp_resync_total)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second item was taken while one was in work.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("A waiting result was overwritten.");

   a_submit_or_resync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_submit_valid && rsp_resync))
      else $error("A result carries both a submitted frame and a resync.");

endmodule
`default_nettype wire

FILE: bench/ajbc_checker.sv
// Checker for the adaptive jitter buffer controller: watches the request, response and
// register ports, predicts every response and compares all of its fields at once. Needs ajbc_pkg.
`timescale 1ns / 1ps
module ajbc_checker
   import ajbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [OP_W-1:0]        req_op,
   input  logic [BYTES_W-1:0]     req_frame_bytes,
   input  logic [NOW_W-1:0]       req_now_us,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_accepted,
   input  logic                   rsp_submit_valid,
   input  logic [DUR_W-1:0]       rsp_submit_ms,
   input  logic [DROPS_W-1:0]     rsp_dropped_now,
   input  logic                   rsp_resync,
   input  logic [PROF_W-1:0]      rsp_profile,
   input  logic [SUM_OUT_W-1:0]   rsp_pending_ms,
   input  logic [SUM_OUT_W-1:0]   rsp_submitted_ms,
   input  logic [TOTAL_W-1:0]     rsp_dropped_total,
   input  logic [TOTAL_W-1:0]     rsp_played_total,
   input  logic [RS_TOTAL_W-1:0]  rsp_resync_total,
   output int                     failures,
   output int                     reports_owed
);

   localparam int PDEPTH = 16;
   localparam int FDEPTH = 10;
   localparam int EXP_DEPTH = 64;
   localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic                  accepted;
      logic                  submit_valid;
      logic [DUR_W-1:0]      submit_ms;
      logic [DROPS_W-1:0]    drop_burst;
      logic                  resync;
      logic [PROF_W-1:0]     profile;
      logic [SUM_OUT_W-1:0]  pend_level;
      logic [SUM_OUT_W-1:0]  flight_level;
      logic [TOTAL_W-1:0]    dropped_total;
      logic [TOTAL_W-1:0]    played_total;
      logic [RS_TOTAL_W-1:0] resync_total;
   } report_type;

   report_type expected_reports[EXP_DEPTH];
   int unsigned exp_wr = 0, exp_rd = 0;

   logic [RATE_W-1:0]  rate_reg;
   logic [CHAN_W-1:0]  chan_reg;
   logic [LIMIT_W-1:0] max_pend_reg, hard_reg, target_reg, soft_reg, cap_reg;
   logic [HOLD_W-1:0]  hold_reg;

   logic [DUR_W-1:0] pend_dur[PDEPTH];
   logic [DUR_W-1:0] flight_dur[FDEPTH];
   int unsigned pend_head, pend_cnt, flight_head, flight_cnt;
   int unsigned pend_sum, flight_sum, drops_this, played_count, overloads;
   logic running;
   longint unsigned started_at, recovery_until, last_overload, last_resync;
   logic [TOTAL_W-1:0] drop_total, play_total;
   logic [RS_TOTAL_W-1:0] rs_tally;
   int mismatches = 0;

   assign failures = mismatches;
   assign reports_owed = int'(exp_wr - exp_rd);

   function automatic logic [DUR_W-1:0] frame_ms(logic [BYTES_W-1:0] bytes);
      longint unsigned bps, d;
      bps = longint'(rate_reg) * chan_reg * 2;
      if (bps == 0 || bytes == 0) return '0;
      d = (longint'(bytes) * 1000 + bps - 1) / bps;
      if (d < 1) d = 1;
      if (d > 255) d = 255;
      return d[DUR_W-1:0];
   endfunction

   function automatic profile_type profile_at(longint unsigned now);
      if (recovery_until > now) return PROF_RECOVERY;
      if (started_at > 0 && now > started_at && now - started_at >= 200000 &&
          played_count >= 14) return PROF_STEADY;
      return PROF_STARTUP;
   endfunction

   function automatic int unsigned cap_of(profile_type p);
      return p == PROF_RECOVERY ? 60 : (p == PROF_STEADY ? cap_reg : 50);
   endfunction

   function automatic int unsigned target_of(profile_type p);
      return p == PROF_RECOVERY ? 70 : (p == PROF_STEADY ? target_reg : 60);
   endfunction

   function automatic int unsigned soft_of(profile_type p);
      return p == PROF_RECOVERY ? 90 : (p == PROF_STEADY ? soft_reg : 80);
   endfunction

   task automatic drop_oldest_frame();
      pend_sum -= pend_dur[pend_head];
      pend_head = (pend_head + 1) % PDEPTH;
      pend_cnt--;
      if (drop_total != '1) drop_total++;
      drops_this++;
   endtask

   task automatic trim_total_to(int unsigned limit);
      while (pend_cnt > 0 && pend_sum + flight_sum > limit) drop_oldest_frame();
   endtask

   task automatic clear_queues();
      pend_head = 0; pend_cnt = 0; pend_sum = 0;
      flight_head = 0; flight_cnt = 0; flight_sum = 0;
   endtask

   task automatic count_overload(longint unsigned now, profile_type p, output bit resync);
      longint unsigned t;
      resync = 0;
      if (last_overload == 0 || (now >= last_overload && now - last_overload > 800000))
         overloads = 0;
      last_overload = now;
      if (overloads < 15) overloads++;
      if (overloads >= 2) begin
         t = now + hold_reg;
         if (t > TIME_MAX) t = TIME_MAX;
         if (t > recovery_until) recovery_until = t;
      end
      if (overloads >= 5 &&
          (last_resync == 0 || (now >= last_resync && now - last_resync >= 1500000))) begin
         trim_total_to(70);
         last_resync = now;
         overloads = 0;
         if (rs_tally != '1) rs_tally++;
         resync = 1;
      end else begin
         trim_total_to(target_of(p));
      end
   endtask

   task automatic predict_buffer_step(logic [OP_W-1:0] op, logic [BYTES_W-1:0] bytes,
                                      longint unsigned now);
      report_type r;
      logic [DUR_W-1:0] d;
      profile_type p;
      bit rs;
      r = '0;
      drops_this = 0;
      rs = 0;
      case (op)
         OP_FRAME: begin
            if (running && bytes != 0) begin
               d = frame_ms(bytes);
               if (pend_cnt >= PDEPTH) drop_oldest_frame();
               pend_dur[(pend_head + pend_cnt) % PDEPTH] = d;
               pend_cnt++;
               pend_sum += d;
               r.accepted = 1;
               while (pend_cnt > 0 && pend_sum > max_pend_reg) drop_oldest_frame();
               trim_total_to(hard_reg);
            end
         end
         OP_SERVICE: begin
            if (running) begin
               p = profile_at(now);
               if (pend_sum + flight_sum > soft_of(p)) count_overload(now, p, rs);
               if (rs) begin
                  flight_head = 0; flight_cnt = 0; flight_sum = 0;
                  started_at = now;
                  played_count = 0;
               end else begin
                  p = profile_at(now);
                  if (pend_cnt > 0 && flight_cnt < FDEPTH && flight_sum < cap_of(p)) begin
                     d = pend_dur[pend_head];
                     pend_sum -= d;
                     pend_head = (pend_head + 1) % PDEPTH;
                     pend_cnt--;
                     flight_dur[(flight_head + flight_cnt) % FDEPTH] = d;
                     flight_cnt++;
                     flight_sum += d;
                     r.submit_valid = 1;
                     r.submit_ms = d;
                  end
               end
            end
         end
         OP_DONE: begin
            if (flight_cnt > 0) begin
               flight_sum -= flight_dur[flight_head];
               flight_head = (flight_head + 1) % FDEPTH;
               flight_cnt--;
               if (play_total != '1) play_total++;
               if (played_count < 16'hFFFF) played_count++;
            end
         end
         OP_OPEN: begin
            clear_queues();
            running = 1;
            started_at = now;
            played_count = 0;
            recovery_until = 0; last_overload = 0; last_resync = 0;
            overloads = 0;
            drop_total = '0; play_total = '0; rs_tally = '0;
         end
         OP_STOP: begin
            running = 0;
            clear_queues();
         end
         default: ;
      endcase
      r.resync = rs;
      r.drop_burst = DROPS_W'(drops_this > 31 ? 31 : drops_this);
      r.profile = profile_at(now);
      r.pend_level = SUM_OUT_W'(pend_sum > 4095 ? 4095 : pend_sum);
      r.flight_level = SUM_OUT_W'(flight_sum > 4095 ? 4095 : flight_sum);
      r.dropped_total = drop_total;
      r.played_total = play_total;
      r.resync_total = rs_tally;
      expected_reports[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endtask

   always @(posedge clock) begin
      report_type exp_r, got;
      if (reset) begin
         rate_reg <= RESET_SAMPLE_RATE; chan_reg <= RESET_CHANNELS;
         max_pend_reg <= RESET_MAX_PENDING; hard_reg <= RESET_HARD_TOTAL;
         target_reg <= RESET_STEADY_TARGET; soft_reg <= RESET_STEADY_SOFT;
         cap_reg <= RESET_STEADY_CAP; hold_reg <= RESET_RECOVERY_HOLD;
         clear_queues();
         running = 0;
         started_at = 0; recovery_until = 0; last_overload = 0; last_resync = 0;
         played_count = 0; overloads = 0;
         drop_total = '0; play_total = '0; rs_tally = '0;
         exp_wr = 0;
         exp_rd = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_accepted, rsp_submit_valid, rsp_submit_ms, rsp_dropped_now,
                    rsp_resync, rsp_profile, rsp_pending_ms, rsp_submitted_ms,
                    rsp_dropped_total, rsp_played_total, rsp_resync_total};
            if (exp_wr == exp_rd) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: unexpected response item %p", $realtime, got);
            end else begin
               exp_r = expected_reports[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got != exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: response mismatch\n  expected %p\n  actual   %p",
                              $realtime, exp_r, got);
               end
            end
         end
         if (req_valid && req_ready)
            predict_buffer_step(req_op, req_frame_bytes, req_now_us);
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_SAMPLE_RATE:   rate_reg <= csr_wdata[RATE_W-1:0];
               CSR_CHANNEL_COUNT: chan_reg <= csr_wdata[CHAN_W-1:0];
               CSR_MAX_PENDING:   max_pend_reg <= csr_wdata[LIMIT_W-1:0];
               CSR_HARD_TOTAL:    hard_reg <= csr_wdata[LIMIT_W-1:0];
               CSR_STEADY_TARGET: target_reg <= csr_wdata[LIMIT_W-1:0];
               CSR_STEADY_SOFT:   soft_reg <= csr_wdata[LIMIT_W-1:0];
               CSR_STEADY_CAP:    cap_reg <= csr_wdata[LIMIT_W-1:0];
               CSR_RECOVERY_HOLD: hold_reg <= csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: bench/tb.sv
// Top of the jitter buffer controller testbench: clock, reset, register phases and items.
// Depends on ajbc_pkg, adaptive_jitter_buffer_controller and ajbc_checker.
`timescale 1ns / 1ps
module tb;
   import ajbc_pkg::*;

   localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;

   logic clock = 0, reset = 1;
   logic csr_wen = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 0, req_ready;
   logic [OP_W-1:0] req_op = '0;
   logic [BYTES_W-1:0] req_frame_bytes = '0;
   logic [NOW_W-1:0] req_now_us = '0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_accepted, rsp_submit_valid, rsp_resync;
   logic [DUR_W-1:0] rsp_submit_ms;
   logic [DROPS_W-1:0] rsp_dropped_now;
   logic [PROF_W-1:0] rsp_profile;
   logic [SUM_OUT_W-1:0] rsp_pending_ms, rsp_submitted_ms;
   logic [TOTAL_W-1:0] rsp_dropped_total, rsp_played_total;
   logic [RS_TOTAL_W-1:0] rsp_resync_total;
   int failures, reports_owed;
   int send_idle = 34, recv_idle = 61;
   longint unsigned clock_us;

   always #5 clock = ~clock;

   adaptive_jitter_buffer_controller dut (.*);
   ajbc_checker u_checker (.*);

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic send_item(op_type op, logic [BYTES_W-1:0] bytes, longint unsigned now);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_frame_bytes <= bytes;
      req_now_us <= now[NOW_W-1:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (reports_owed != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 0;
   endtask

   task automatic write_all(int rate, int chans, int maxp, int hard, int tgt, int soft_lim,
                            int cap, int hold);
      write_reg(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(chans));
      write_reg(CSR_MAX_PENDING, CSR_DATA_W'(maxp));
      write_reg(CSR_HARD_TOTAL, CSR_DATA_W'(hard));
      write_reg(CSR_STEADY_TARGET, CSR_DATA_W'(tgt));
      write_reg(CSR_STEADY_SOFT, CSR_DATA_W'(soft_lim));
      write_reg(CSR_STEADY_CAP, CSR_DATA_W'(cap));
      write_reg(CSR_RECOVERY_HOLD, CSR_DATA_W'(hold));
      @(posedge clock);
   endtask

   function automatic logic [BYTES_W-1:0] frame_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 8) return '1;
      if (roll < 15) return BYTES_W'($urandom);
      return BYTES_W'($urandom_range(1, 4) * 1920 + $urandom_range(0, 200) - 100);
   endfunction

   function automatic longint unsigned next_time(longint unsigned now);
      int roll;
      roll = $urandom_range(999);
      if (roll < 20) return now > 1000000 ? now - $urandom_range(1, 1000000) : 0;
      if (roll < 40) return now + $urandom_range(500000, 3000000);
      if (roll < 45) return {$urandom, $urandom} & TIME_MAX;
      if (roll < 48) return TIME_MAX - $urandom_range(0, 2000000);
      if (roll < 80) return now;
      return (now + $urandom_range(1, 12000)) & TIME_MAX;
   endfunction

   task automatic random_session(int count);
      int frame_w, svc_w, roll, op_roll;
      send_item(OP_OPEN, BYTES_W'($urandom), clock_us);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            frame_w = $urandom_range(25, 60);
            svc_w = frame_w + $urandom_range(15, 40);
         end
         clock_us = next_time(clock_us);
         roll = $urandom_range(99);
         if (roll < frame_w) send_item(OP_FRAME, frame_length(), clock_us);
         else if (roll < svc_w) send_item(OP_SERVICE, BYTES_W'($urandom), clock_us);
         else if (roll < 96) send_item(OP_DONE, BYTES_W'($urandom), clock_us);
         else if (roll < 98) send_item(OP_OPEN, BYTES_W'($urandom), clock_us);
         else if (roll < 99) send_item(OP_STOP, BYTES_W'($urandom), clock_us);
         else begin
            op_roll = $urandom_range(5, 7);
            send_item(op_type'(op_roll), BYTES_W'($urandom), clock_us);
         end
      end
   endtask

   initial begin
      int per_phase;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      clock_us = 0;
      send_item(OP_FRAME, 16'd1920, 0);
      send_item(OP_SERVICE, '0, 0);
      send_item(OP_OPEN, '0, 0);
      send_item(OP_FRAME, '0, 10);
      send_item(OP_FRAME, 16'hFFFF, 20);
      send_item(OP_FRAME, 16'd1, 30);
      for (int i = 0; i < 6; i++) send_item(OP_FRAME, 16'd1920, 40 + i);
      send_item(OP_SERVICE, '0, 100);
      send_item(OP_SERVICE, '0, 200);
      send_item(OP_DONE, '0, 300);
      send_item(OP_DONE, '0, 400);
      send_item(OP_DONE, '0, 500);
      send_item(op_type'(5), '0, 600);
      send_item(op_type'(6), '0, 700);
      send_item(op_type'(7), '1, 800);
      send_item(OP_STOP, '0, 900);
      send_item(OP_SERVICE, '0, 1000);
      send_item(OP_FRAME, 16'd1920, 1100);
      send_item(OP_OPEN, '1, TIME_MAX - 10);
      send_item(OP_FRAME, 16'd1920, TIME_MAX);
      send_item(OP_SERVICE, '0, TIME_MAX);
      clock_us = 1000;
      drain();

      per_phase = 254;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: write_all(1, 1, 0, 0, 0, 0, 0, 0);
            2: write_all(192000, 8, 1023, 1023, 1023, 1023, 1023, 10000000);
            3: write_all(0, 2, 200, 250, 60, 80, 50, 1500000);
            4: write_all(48000, 2, 120, 130, 50, 70, 40, 1500000);
            5: write_all($urandom_range(8000, 192000), $urandom_range(1, 8),
                         $urandom_range(20, 300), $urandom_range(20, 400),
                         $urandom_range(0, 150), $urandom_range(20, 200),
                         $urandom_range(0, 120), $urandom_range(0, 3000000));
            default: ;
         endcase
         if (phase == 2) begin
            send_idle = 61;
            recv_idle = 34;
         end else if (phase == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         random_session(per_phase / 2);
         drain();
         if (phase == 3) write_reg(CSR_CHANNEL_COUNT, '0);
         random_session(per_phase - per_phase / 2);
         drain();
      end

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ajbc_pkg.sv
rtl/core/ajbc_datapath.sv
rtl/core/ajbc_ctrl.sv
rtl/core/adaptive_jitter_buffer_controller.sv
bench/ajbc_checker.sv
bench/tb.sv
